[rtl/core/ppu_pkg.sv]
// Package for the perspective projection unit.
// Holds parameter defaults, register indexes and register reset values.
// No dependencies.
package ppu_pkg;

    localparam int FRAC_BITS_DEF   = 14;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_SIN_THETA  = 3'd0;
    localparam t_reg_idx REG_COS_THETA  = 3'd1;
    localparam t_reg_idx REG_SIN_PHI    = 3'd2;
    localparam t_reg_idx REG_COS_PHI    = 3'd3;
    localparam t_reg_idx REG_EYE_RADIUS = 3'd4;
    localparam t_reg_idx REG_SCREEN_DST = 3'd5;

    localparam logic [15:0] RST_SIN_THETA  = 16'd0;
    localparam logic [15:0] RST_COS_THETA  = 16'd16384;
    localparam logic [15:0] RST_SIN_PHI    = 16'd16384;
    localparam logic [15:0] RST_COS_PHI    = 16'd0;
    localparam logic [15:0] RST_EYE_RADIUS = 16'd1000;
    localparam logic [15:0] RST_SCREEN_DST = 16'd800;

endpackage

[rtl/core/ppu_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// The first stage flags quotients that do not fit in QW bits.
// Depends on nothing.
module ppu_div #(
    parameter int XW = 70,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_num,
    input  logic [XW-1:0] i_den,
    output logic [QW-1:0] o_q,
    output logic          o_ovf
);

    logic [XW-1:0] r_rem [QW+1];
    logic [XW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_ovf [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >= (i_den << QW));
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        localparam int K = QW - j;
        logic [XW-1:0] sh;
        logic          ge;
        logic [XW-1:0] n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            sh    = r_den[j-1] << K;
            ge    = (r_rem[j-1] >= sh);
            n_rem = ge ? (r_rem[j-1] - sh) : r_rem[j-1];
            n_q    = r_q[j-1];
            n_q[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_den[j] <= r_den[j-1];
                r_q[j]   <= n_q;
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule

[rtl/core/perspective_projection_unit.sv]
// Perspective projection unit: rotates a world point into view space and
// divides by depth. Depends on ppu_pkg and ppu_div.
// Throughput: one word per cycle while the output is not stalled.
// The divider has one stage per quotient bit.
// The whole pipeline stalls only while the output word waits for i_m_tready.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module perspective_projection_unit
    import ppu_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_TW  = ((3*COORD_WIDTH + 16 + 7) / 8) * 8,
    localparam int OUT_TW = ((2*COORD_WIDTH + 16 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // world_x, world_y, world_z, weight_in, zero padding
    input  logic [IN_TW-1:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // screen_x, screen_y, weight_out, zero padding
    output logic [OUT_TW-1:0] o_m_tdata,
    // behind_eye, clipped
    output logic [1:0]        o_m_tuser,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output logic              o_pready
);

    localparam int CW = COORD_WIDTH;
    localparam int VW = CW + FRAC_BITS + 20;
    localparam int HW = VW - 16;
    localparam int XW = VW + CW + 18;
    localparam int QW = CW + 1;
    localparam int PW = CW + 18;
    localparam logic [QW-1:0] LIM_POS = QW'((1 << (CW - 1)) - 1);
    localparam logic [QW-1:0] LIM_NEG = QW'(1 << (CW - 1));

    typedef struct packed {
        logic        valid;
        logic        neg_x;
        logic        neg_y;
        logic        behind;
        logic [15:0] weight;
    } t_side;

    // Configuration registers
    logic [15:0] r_sin_theta, r_cos_theta, r_sin_phi, r_cos_phi;
    logic [15:0] r_eye_radius, r_screen_dst;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign cfg_idx  = i_paddr[4:2];
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_theta  <= RST_SIN_THETA;
            r_cos_theta  <= RST_COS_THETA;
            r_sin_phi    <= RST_SIN_PHI;
            r_cos_phi    <= RST_COS_PHI;
            r_eye_radius <= RST_EYE_RADIUS;
            r_screen_dst <= RST_SCREEN_DST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SIN_THETA:  r_sin_theta  <= i_pwdata[15:0];
                REG_COS_THETA:  r_cos_theta  <= i_pwdata[15:0];
                REG_SIN_PHI:    r_sin_phi    <= i_pwdata[15:0];
                REG_COS_PHI:    r_cos_phi    <= i_pwdata[15:0];
                REG_EYE_RADIUS: r_eye_radius <= i_pwdata[15:0];
                REG_SCREEN_DST: r_screen_dst <= i_pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SIN_THETA:  o_prdata = CFG_DW'(r_sin_theta);
            REG_COS_THETA:  o_prdata = CFG_DW'(r_cos_theta);
            REG_SIN_PHI:    o_prdata = CFG_DW'(r_sin_phi);
            REG_COS_PHI:    o_prdata = CFG_DW'(r_cos_phi);
            REG_EYE_RADIUS: o_prdata = CFG_DW'(r_eye_radius);
            REG_SCREEN_DST: o_prdata = CFG_DW'(r_screen_dst);
            default:        o_prdata = '0;
        endcase
    end

    // Angle products, floored to the fixed-point scale
    logic signed [31:0] n_stcp, n_ctcp, n_stsp, n_spct;
    logic signed [31:0] r_stcp, r_ctcp, r_stsp, r_spct;

    assign n_stcp = ($signed(r_sin_theta) * $signed(r_cos_phi)) >>> FRAC_BITS;
    assign n_ctcp = ($signed(r_cos_theta) * $signed(r_cos_phi)) >>> FRAC_BITS;
    assign n_stsp = ($signed(r_sin_theta) * $signed(r_sin_phi)) >>> FRAC_BITS;
    assign n_spct = ($signed(r_sin_phi) * $signed(r_cos_theta)) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_stcp <= n_stcp;
        r_ctcp <= n_ctcp;
        r_stsp <= n_stsp;
        r_spct <= n_spct;
    end

    logic en;
    logic r_out_valid;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // Stage 1: input capture
    logic                 r1_v;
    logic signed [CW-1:0] r1_x, r1_y, r1_z;
    logic [15:0]          r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x <= i_s_tdata[CW-1:0];
            r1_y <= i_s_tdata[2*CW-1:CW];
            r1_z <= i_s_tdata[3*CW-1:2*CW];
            r1_w <= i_s_tdata[3*CW+15:3*CW];
        end
    end

    // Stage 2: rotation products
    logic                 r2_v;
    logic [15:0]          r2_w;
    logic signed [VW-1:0] r2_ctx, r2_stz, r2_spy, r2_cpy;
    logic signed [VW-1:0] r2_stcpx, r2_ctcpz, r2_stspx, r2_spctz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_w     <= r1_w;
            r2_ctx   <= VW'(PW'($signed(r_cos_theta)) * PW'(r1_x));
            r2_stz   <= VW'(PW'($signed(r_sin_theta)) * PW'(r1_z));
            r2_spy   <= VW'(PW'($signed(r_sin_phi)) * PW'(r1_y));
            r2_cpy   <= VW'(PW'($signed(r_cos_phi)) * PW'(r1_y));
            r2_stcpx <= VW'(PW'(r_stcp) * PW'(r1_x));
            r2_ctcpz <= VW'(PW'(r_ctcp) * PW'(r1_z));
            r2_stspx <= VW'(PW'(r_stsp) * PW'(r1_x));
            r2_spctz <= VW'(PW'(r_spct) * PW'(r1_z));
        end
    end

    // Stage 3: view coordinates
    logic                 r3_v;
    logic [15:0]          r3_w;
    logic signed [VW-1:0] r3_vx, r3_vy, r3_vz;
    logic signed [VW-1:0] rq;

    assign rq = signed'(VW'(r_eye_radius) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_w  <= r2_w;
            r3_vx <= r2_ctx - r2_stz;
            r3_vy <= r2_spy - r2_stcpx - r2_ctcpz;
            r3_vz <= rq - r2_stspx - r2_cpy - r2_spctz;
        end
    end

    // Stage 4: magnitudes and depth test
    t_side         r4_sb, n4_sb;
    logic [VW-1:0] r4_magx, r4_magy, r4_den;

    always_comb begin
        n4_sb.valid  = r3_v;
        n4_sb.neg_x  = r3_vx[VW-1];
        n4_sb.neg_y  = r3_vy[VW-1];
        n4_sb.behind = r3_vz[VW-1] || (r3_vz == '0);
        n4_sb.weight = r3_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_sb <= '0;
        end else if (en) begin
            r4_sb <= n4_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_magx <= r3_vx[VW-1] ? VW'(-r3_vx) : VW'(r3_vx);
            r4_magy <= r3_vy[VW-1] ? VW'(-r3_vy) : VW'(r3_vy);
            r4_den  <= n4_sb.behind ? VW'(1) : VW'(r3_vz);
        end
    end

    // Stage 5: partial products of screen distance times magnitude
    t_side         r5_sb;
    logic [47:0]   r5_plox, r5_ploy;
    logic [HW-1:0] r5_phix, r5_phiy;
    logic [VW-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_sb <= '0;
        end else if (en) begin
            r5_sb <= r4_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_plox <= 48'(r_screen_dst * r4_magx[31:0]);
            r5_ploy <= 48'(r_screen_dst * r4_magy[31:0]);
            r5_phix <= HW'(r_screen_dst * r4_magx[VW-1:32]);
            r5_phiy <= HW'(r_screen_dst * r4_magy[VW-1:32]);
            r5_den  <= r4_den;
        end
    end

    // Stage 6: full numerators
    t_side         r6_sb;
    logic [XW-1:0] r6_numx, r6_numy, r6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_sb <= '0;
        end else if (en) begin
            r6_sb <= r5_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_numx <= (XW'(r5_phix) << 32) + XW'(r5_plox);
            r6_numy <= (XW'(r5_phiy) << 32) + XW'(r5_ploy);
            r6_den  <= XW'(r5_den);
        end
    end

    // Division lanes
    logic [QW-1:0] qx, qy;
    logic          ovfx, ovfy;

    ppu_div #(.XW(XW), .QW(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_numx),
        .i_den (r6_den),
        .o_q   (qx),
        .o_ovf (ovfx)
    );

    ppu_div #(.XW(XW), .QW(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_numy),
        .i_den (r6_den),
        .o_q   (qy),
        .o_ovf (ovfy)
    );

    t_side r_sb_dly [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_sb_dly[k] <= '0;
            end
        end else if (en) begin
            r_sb_dly[0] <= r6_sb;
            for (int k = 1; k <= QW; k++) begin
                r_sb_dly[k] <= r_sb_dly[k-1];
            end
        end
    end

    // Sign and saturation; returns {clipped, value}
    function automatic logic [CW:0] sat_fn(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
        logic          sat;
        logic [QW-1:0] nq;
        if (neg) begin
            sat = ovf || (q > LIM_NEG);
            nq  = sat ? LIM_NEG : q;
            return {sat, CW'(-nq)};
        end else begin
            sat = ovf || (q > LIM_POS);
            nq  = sat ? LIM_POS : q;
            return {sat, CW'(nq)};
        end
    endfunction

    logic [CW:0] satx, saty;
    t_side       sb_last;

    assign sb_last = r_sb_dly[QW];
    assign satx    = sat_fn(qx, ovfx, sb_last.neg_x);
    assign saty    = sat_fn(qy, ovfy, sb_last.neg_y);

    // Output register
    logic [CW-1:0] r_sx, r_sy;
    logic [15:0]   r_w;
    logic          r_behind, r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sb_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w      <= sb_last.weight;
            r_behind <= sb_last.behind;
            r_sx     <= sb_last.behind ? '0 : satx[CW-1:0];
            r_sy     <= sb_last.behind ? '0 : saty[CW-1:0];
            r_clip   <= !sb_last.behind && (satx[CW] || saty[CW]);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TW'({r_w, r_sy, r_sx});
    assign o_m_tuser  = {r_clip, r_behind};

endmodule

[rtl/core/ppu_checker.sv]
// Port-level checks for the perspective projection unit, bound to the top level.
// Depends on ppu_pkg and perspective_projection_unit.
module ppu_props
    import ppu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int OUT_TW      = 48
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_TW-1:0] o_m_tdata,
    input logic [1:0]        o_m_tuser
);

    localparam int CW = COORD_WIDTH;

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            (o_m_tdata[2*CW-1:0] == '0) && !o_m_tuser[1])
        else $error("behind-eye word carries nonzero coordinates or clip");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output slot state");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled output word changed");

endmodule

bind perspective_projection_unit ppu_props #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_TW      (OUT_TW)
) u_ppu_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[bench/ppu_checker.sv]
// Checker for the perspective projection unit: watches both stream channels,
// predicts each output word from the accepted input word and the register shadow.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_checker
    import ppu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        behind;
        logic        clip;
        logic [15:0] wgt;
        logic [15:0] sy;
        logic [15:0] sx;
    } t_screen;

    logic signed [15:0] st, ct, sp, cp;
    logic [15:0] radius, sdist;
    t_screen screen_q[$];

    function automatic longint floor_q(longint p);
        return p >>> 14;
    endfunction

    function automatic logic [15:0] divide_sat(longint v, longint den, inout logic clip);
        longint mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag * longint'(sdist)) / den;
        if (v < 0) begin
            if (q > 32768) begin
                q = 32768;
                clip = 1'b1;
            end
            return 16'(-q);
        end
        if (q > 32767) begin
            q = 32767;
            clip = 1'b1;
        end
        return 16'(q);
    endfunction

    function automatic t_screen project_point(logic [63:0] d);
        longint x, y, z, vx, vy, vz;
        longint lst, lct, lsp, lcp;
        t_screen r;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        lst = longint'(st);
        lct = longint'(ct);
        lsp = longint'(sp);
        lcp = longint'(cp);
        vx = lct * x - lst * z;
        vy = -floor_q(lst * lcp) * x + lsp * y - floor_q(lct * lcp) * z;
        vz = -floor_q(lst * lsp) * x - lcp * y - floor_q(lsp * lct) * z
             + (longint'(radius) <<< 14);
        r = '0;
        r.wgt = d[63:48];
        if (vz <= 0) begin
            r.behind = 1'b1;
        end else begin
            r.sx = divide_sat(vx, vz, r.clip);
            r.sy = divide_sat(vy, vz, r.clip);
        end
        return r;
    endfunction

    assign o_pending = screen_q.size();

    always @(posedge i_clk) begin
        t_screen e, a;
        if (!i_rst_n) begin
            st <= $signed(RST_SIN_THETA);
            ct <= $signed(RST_COS_THETA);
            sp <= $signed(RST_SIN_PHI);
            cp <= $signed(RST_COS_PHI);
            radius <= RST_EYE_RADIUS;
            sdist <= RST_SCREEN_DST;
            screen_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_SIN_THETA:  st <= i_pwdata[15:0];
                    REG_COS_THETA:  ct <= i_pwdata[15:0];
                    REG_SIN_PHI:    sp <= i_pwdata[15:0];
                    REG_COS_PHI:    cp <= i_pwdata[15:0];
                    REG_EYE_RADIUS: radius <= i_pwdata[15:0];
                    REG_SCREEN_DST: sdist <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                screen_q.push_back(project_point(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                a = {i_m_tuser[0], i_m_tuser[1], i_m_tdata};
                if (screen_q.size() == 0) begin
                    $error("unexpected word %h", a);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = screen_q.pop_front();
                    if (e.sx !== a.sx) $error("screen_x exp %0d got %0d",
                        $signed(e.sx), $signed(a.sx));
                    if (e.sy !== a.sy) $error("screen_y exp %0d got %0d",
                        $signed(e.sy), $signed(a.sy));
                    if (e.wgt !== a.wgt) $error("weight_out exp %0d got %0d", e.wgt, a.wgt);
                    if (e.behind !== a.behind) $error("behind_eye exp %0b got %0b",
                        e.behind, a.behind);
                    if (e.clip !== a.clip) $error("clipped exp %0b got %0b", e.clip, a.clip);
                    if (e !== a) o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

endmodule

[bench/tb.sv]
// Testbench top for the perspective projection unit: drives points and register
// writes under varied idling and gives the verdict. Depends on ppu_pkg, ppu_checker.
`timescale 1ns / 1ps
module tb;
    import ppu_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;
    logic [1:0]  m_user;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          send_idle = 0, recv_stall = 0, hold_off = 0, quiet = 0;
    bit          done = 1'b0;

    always #5 i_clk = ~i_clk;

    perspective_projection_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    ppu_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet > 20000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_point(logic [15:0] x, y, z, w);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {w, z, y, x};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_view(logic [15:0] a, b, c, d, r, s);
        reg_write(REG_SIN_THETA, a);
        reg_write(REG_COS_THETA, b);
        reg_write(REG_SIN_PHI, c);
        reg_write(REG_COS_PHI, d);
        reg_write(REG_EYE_RADIUS, r);
        reg_write(REG_SCREEN_DST, s);
    endtask

    task automatic random_points(int n);
        logic [15:0] x, y, z;
        repeat (n) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
            if ($urandom_range(3) != 0) begin
                x = 16'($signed(x) >>> $urandom_range(15));
                y = 16'($signed(y) >>> $urandom_range(15));
                z = 16'($signed(z) >>> $urandom_range(15));
            end
            send_point(x, y, z, 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] ext[6];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_point(16'd10, 16'd20, 16'd30, 16'h1234);
        send_point(16'd0, 16'd1000, 16'd0, 16'hFFFF);
        send_point(16'd0, 16'd2000, 16'd0, 16'h0000);
        for (int i = 0; i < 6; i++) begin
            send_point(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6], ext[5 - i]);
        end
        drain();
        set_view(16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'hFFFF, 16'hFFFF);
        send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'hAAAA);
        send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h5555);
        send_point(16'd1, 16'd1, 16'd1, 16'd1);
        send_point(16'd5, 16'hFFF0, 16'd7, 16'd3);
        drain();
        set_view(16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_point(16'd100, 16'd100, 16'd0, 16'd9);
        send_point(16'd100, 16'd100, 16'hFF00, 16'd9);
        drain();
        set_view(16'd11585, 16'd11585, 16'd8192, 16'd14189, 16'd5, 16'd60000);
        send_point(16'd3, 16'd1, 16'hFFFE, 16'd1);
        send_point(16'h7FFF, 16'h7FFF, 16'h8000, 16'd2);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 71 : 38) : 0;
            recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 71 : 38) : 0;
            if (ph == 4) hold_off = 300;
            random_points(110);
            drain();
            set_view(16'($signed($urandom_range(32768)) - 16384),
                     16'($signed($urandom_range(32768)) - 16384),
                     16'($signed($urandom_range(32768)) - 16384),
                     16'($signed($urandom_range(32768)) - 16384),
                     (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
                     16'($urandom));
        end
        send_idle = 0;
        recv_stall = 0;
        random_points(60);
        drain();
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ppu_pkg.sv
rtl/core/ppu_div.sv
rtl/core/perspective_projection_unit.sv
rtl/core/ppu_checker.sv
bench/ppu_checker.sv
bench/tb.sv
